[rtl/hashed_key_event_census_unit_macros.svh]
// Assertion helpers for the census unit RTL, used by the table sequencer.
`ifndef HASHED_KEY_EVENT_CENSUS_UNIT_MACROS_SVH
`define HASHED_KEY_EVENT_CENSUS_UNIT_MACROS_SVH

// Checked at every rising edge outside of reset.
`define HKEC_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("hkec assertion failed");

// Checked at every rising edge, reset included.
`define HKEC_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) (prop)) \
      else $error("hkec assertion failed");

`endif

[rtl/hkec_pkg.sv]
`default_nettype none
package hkec_pkg;
   // SLOTS must be a power of two no larger than the report index range.
   localparam int SLOTS = 512;
   localparam int IDX_W = $clog2(SLOTS);
   localparam int KEY_W = 64;
   localparam int CNT_W = 64;
   localparam int SLOT_W = 9;
   localparam logic [63:0] FIB_MULT = 64'd11400714819323198485;

   localparam logic OP_RECORD = 1'b0;
   localparam logic OP_REPORT = 1'b1;

   typedef struct packed {
      logic              opcode;
      logic [KEY_W-1:0]  key;
      logic              head;
      logic [SLOT_W-1:0] slot;
      logic [IDX_W-1:0]  home;
   } cmd_type;

   typedef struct packed {
      logic             used;
      logic [KEY_W-1:0] key;
      logic [CNT_W-1:0] head;
      logic [CNT_W-1:0] body;
   } entry_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PROBE
   } back_state_type;
endpackage
`default_nettype wire

[rtl/hkec_front.sv]
`default_nettype none
module hkec_front (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           hold,
   input  wire                           push,
   output logic                          full,
   input  wire                           req_opcode,
   input  wire  [hkec_pkg::KEY_W-1:0]    req_lookup_key,
   input  wire                           req_count_head,
   input  wire  [hkec_pkg::SLOT_W-1:0]   req_report_slot,
   output logic                          q_push,
   output hkec_pkg::cmd_type             q_data,
   input  wire                           q_full
);
   localparam int W = hkec_pkg::IDX_W;

   logic                 s1_v_ff, s1_v_in, s2_v_ff, s2_v_in;
   hkec_pkg::cmd_type    s1_cmd_ff, s1_cmd_in, s2_cmd_ff, s2_cmd_in;
   logic [W-1:0]         s1_lo_ff, s1_lo_in, s1_x_ff, s1_x_in;
   logic [63:0]          lo_prod;
   logic                 advance, s1_load, accept;

   assign advance = !s2_v_ff || !q_full;
   assign s1_load = advance || !s1_v_ff;
   assign full    = hold || !s1_load;
   assign accept  = push && !full;
   assign q_push  = s2_v_ff && !q_full;
   assign q_data  = s2_cmd_ff;

   // Only product bits up to the top of the slot index matter, so the high
   // key and constant halves contribute through narrow cross terms.
   always_comb begin
      lo_prod = {32'd0, req_lookup_key[31:0]} * {32'd0, hkec_pkg::FIB_MULT[31:0]};
      s1_lo_in = lo_prod[32 +: W];
      s1_x_in = W'(req_lookup_key[32 +: W] * hkec_pkg::FIB_MULT[W-1:0])
              + W'(req_lookup_key[W-1:0] * hkec_pkg::FIB_MULT[32 +: W]);
      s1_cmd_in.opcode = req_opcode;
      s1_cmd_in.key    = req_lookup_key;
      s1_cmd_in.head   = req_count_head;
      s1_cmd_in.slot   = req_report_slot;
      s1_cmd_in.home   = '0;
      s1_v_in = s1_load ? accept : s1_v_ff;
      s2_v_in = advance ? s1_v_ff : s2_v_ff;
      s2_cmd_in = s1_cmd_ff;
      s2_cmd_in.home = s1_lo_ff + s1_x_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
      end
      if (s1_load) begin
         s1_cmd_ff <= s1_cmd_in;
         s1_lo_ff  <= s1_lo_in;
         s1_x_ff   <= s1_x_in;
      end
      if (advance) begin
         s2_cmd_ff <= s2_cmd_in;
      end
   end
endmodule
`default_nettype wire

[rtl/hkec_fifo.sv]
`default_nettype none
module hkec_fifo (
   input  wire                clock,
   input  wire                reset,
   input  wire                wr_en,
   input  hkec_pkg::cmd_type  wr_data,
   output logic               wr_full,
   input  wire                rd_en,
   output hkec_pkg::cmd_type  rd_data,
   output logic               rd_empty
);
   hkec_pkg::cmd_type buf_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_wr, do_rd;

   assign wr_full  = (cnt_ff == 2'd2);
   assign rd_empty = (cnt_ff == 2'd0);
   assign rd_data  = buf_ff[rp_ff];
   assign do_wr    = wr_en && !wr_full;
   assign do_rd    = rd_en && !rd_empty;

   always_comb begin
      wp_in  = wp_ff ^ do_wr;
      rp_in  = rp_ff ^ do_rd;
      cnt_in = cnt_ff + {1'b0, do_wr} - {1'b0, do_rd};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (do_wr) begin
         buf_ff[wp_ff] <= wr_data;
      end
   end
endmodule
`default_nettype wire

[rtl/hkec_back.sv]
`default_nettype none
`include "hashed_key_event_census_unit_macros.svh"
module hkec_back (
   input  wire                          clock,
   input  wire                          reset,
   output logic                         clearing,
   input  wire                          q_empty,
   input  hkec_pkg::cmd_type            q_data,
   output logic                         q_pop,
   output logic                         empty,
   input  wire                          pop,
   output logic                         rsp_ok,
   output logic [hkec_pkg::KEY_W-1:0]   rsp_slot_key,
   output logic [hkec_pkg::CNT_W-1:0]   rsp_head_count,
   output logic [hkec_pkg::CNT_W-1:0]   rsp_body_count
);
   localparam int W = hkec_pkg::IDX_W;

   hkec_pkg::entry_type mem [hkec_pkg::SLOTS];
   hkec_pkg::entry_type rdata_ff, wdata, ent;

   hkec_pkg::back_state_type state_ff, state_in;
   hkec_pkg::cmd_type   cmd_ff, cmd_in;
   logic [W-1:0]        addr_ff, addr_in, cnt_ff, cnt_in, clr_ff, clr_in, waddr;
   logic                we, finish, fin_ok, start, match, in_range;
   logic                rsp_v_ff, rsp_v_in;
   logic                ok_ff;
   logic [hkec_pkg::KEY_W-1:0] key_ff;
   logic [hkec_pkg::CNT_W-1:0] head_ff, body_ff;
   hkec_pkg::entry_type rsp_in;

   assign ent      = rdata_ff;
   assign match    = ent.used && (ent.key == cmd_ff.key);
   assign in_range = (32'(cmd_ff.slot) < 32'(hkec_pkg::SLOTS));
   assign start    = !q_empty && (!rsp_v_ff || pop);
   assign clearing = (state_ff == hkec_pkg::ST_CLEAR);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hkec_pkg::ST_CLEAR: begin
            if (clr_ff == W'(hkec_pkg::SLOTS - 1)) state_in = hkec_pkg::ST_IDLE;
         end
         hkec_pkg::ST_IDLE: begin
            if (start) state_in = hkec_pkg::ST_PROBE;
         end
         hkec_pkg::ST_PROBE: begin
            if (finish) state_in = hkec_pkg::ST_IDLE;
         end
         default: state_in = hkec_pkg::ST_CLEAR;
      endcase
   end

   always_comb begin
      q_pop   = 1'b0;
      we      = 1'b0;
      waddr   = addr_ff;
      wdata   = ent;
      finish  = 1'b0;
      fin_ok  = 1'b0;
      cmd_in  = cmd_ff;
      addr_in = addr_ff;
      cnt_in  = cnt_ff;
      clr_in  = clr_ff + 1'b1;
      rsp_in  = '0;
      unique case (state_ff)
         hkec_pkg::ST_CLEAR: begin
            we    = 1'b1;
            waddr = clr_ff;
            wdata = '0;
         end
         hkec_pkg::ST_IDLE: begin
            if (start) begin
               q_pop  = 1'b1;
               cmd_in = q_data;
               cnt_in = '0;
               addr_in = (q_data.opcode == hkec_pkg::OP_REPORT) ?
                         q_data.slot[W-1:0] : q_data.home;
            end
         end
         hkec_pkg::ST_PROBE: begin
            if (cmd_ff.opcode == hkec_pkg::OP_REPORT) begin
               finish = 1'b1;
               if (ent.used && in_range) rsp_in = ent;
            end else if (!ent.used || match) begin
               // A free slot is claimed with both counters starting from zero.
               we         = 1'b1;
               wdata.used = 1'b1;
               wdata.key  = cmd_ff.key;
               wdata.head = (ent.used ? ent.head : '0) + {63'd0, cmd_ff.head};
               wdata.body = (ent.used ? ent.body : '0) + {63'd0, !cmd_ff.head};
               finish     = 1'b1;
               fin_ok     = 1'b1;
               rsp_in.used = 1'b1;
            end else if (cnt_ff == W'(hkec_pkg::SLOTS - 1)) begin
               finish = 1'b1;
            end else begin
               addr_in = addr_ff + 1'b1;
               cnt_in  = cnt_ff + 1'b1;
            end
         end
         default: ;
      endcase
      rsp_v_in = finish ? 1'b1 : (pop ? 1'b0 : rsp_v_ff);
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[addr_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hkec_pkg::ST_CLEAR;
         clr_ff   <= '0;
         rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         rsp_v_ff <= rsp_v_in;
      end
      cmd_ff  <= cmd_in;
      addr_ff <= addr_in;
      cnt_ff  <= cnt_in;
      if (finish) begin
         ok_ff   <= rsp_in.used | fin_ok;
         key_ff  <= rsp_in.key;
         head_ff <= rsp_in.head;
         body_ff <= rsp_in.body;
      end
   end

   assign empty          = !rsp_v_ff;
   assign rsp_ok         = ok_ff;
   assign rsp_slot_key   = key_ff;
   assign rsp_head_count = head_ff;
   assign rsp_body_count = body_ff;

   `HKEC_ASSERT(a_no_rsp_while_clear, clock, reset, clearing |-> !rsp_v_ff)
   `HKEC_ASSERT(a_report_never_writes, clock, reset,
      (state_ff == hkec_pkg::ST_PROBE && cmd_ff.opcode == hkec_pkg::OP_REPORT) |-> !we)
   `HKEC_ASSERT(a_finish_fills_rsp, clock, reset, finish |=> rsp_v_ff)
   `HKEC_ASSERT(a_pop_only_idle, clock, reset, q_pop |-> (state_ff == hkec_pkg::ST_IDLE))
endmodule
`default_nettype wire

[rtl/hashed_key_event_census_unit.sv]
// Event census over 64-bit keys in a 512-slot open-addressed hash table.
// Input channel: drive the req_ fields and raise push; the word is taken at
// a rising edge where push is high and full is low. A record word (opcode 0)
// bumps the head or body counter of lookup_key; a report word (opcode 1)
// reads back slot report_slot.
// Result channel: while empty is low the oldest result sits on the rsp_
// ports; it leaves at a rising edge where pop is high. Exactly one result
// word comes back per input word, in order.
// Path: two hash stages, a two-word queue, then the table sequencer. A
// report reads one slot; a record probes from its home slot onward, up to
// 512 probes when the table is full. The sequencer takes a new word only
// after the last one is finished, as the probe loop walks the slot memory
// through its one read port and one write port; the hash stages and queue
// still take words meanwhile. Reset (synchronous, active high) starts a
// clearing pass that marks all 512 slots free; full stays high until done.
// When pop is held low, one result waits in the output register, the queue
// and hash stages fill, and then full rises until the result is taken.
`default_nettype none
module hashed_key_event_census_unit (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          push,
   output logic                         full,
   input  wire                          req_opcode,
   input  wire  [hkec_pkg::KEY_W-1:0]   req_lookup_key,
   input  wire                          req_count_head,
   input  wire  [hkec_pkg::SLOT_W-1:0]  req_report_slot,
   output logic                         empty,
   input  wire                          pop,
   output logic                         rsp_ok,
   output logic [hkec_pkg::KEY_W-1:0]   rsp_slot_key,
   output logic [hkec_pkg::CNT_W-1:0]   rsp_head_count,
   output logic [hkec_pkg::CNT_W-1:0]   rsp_body_count
);
   logic              clearing, f_push, f_full, q_pop, q_empty;
   hkec_pkg::cmd_type f_data, q_data;

   hkec_front u_front (
      .clock           (clock),
      .reset           (reset),
      .hold            (clearing),
      .push            (push),
      .full            (full),
      .req_opcode      (req_opcode),
      .req_lookup_key  (req_lookup_key),
      .req_count_head  (req_count_head),
      .req_report_slot (req_report_slot),
      .q_push          (f_push),
      .q_data          (f_data),
      .q_full          (f_full)
   );

   hkec_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (f_push),
      .wr_data  (f_data),
      .wr_full  (f_full),
      .rd_en    (q_pop),
      .rd_data  (q_data),
      .rd_empty (q_empty)
   );

   hkec_back u_back (
      .clock          (clock),
      .reset          (reset),
      .clearing       (clearing),
      .q_empty        (q_empty),
      .q_data         (q_data),
      .q_pop          (q_pop),
      .empty          (empty),
      .pop            (pop),
      .rsp_ok         (rsp_ok),
      .rsp_slot_key   (rsp_slot_key),
      .rsp_head_count (rsp_head_count),
      .rsp_body_count (rsp_body_count)
   );
endmodule
`default_nettype wire
